/* rtl/core/assert_macros.svh */
// Assertion macros shared by the downscaler RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, disabled while reset is asserted (active low).
`define AAD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication, disabled while reset is asserted.
`define AAD_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AAD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/aad_pkg.sv */
// Shared types and constants of the area-average downscaler.
// No dependencies; imported by the RAM users and the top level.
package aad_pkg;

    localparam int SUM_W     = 28;
    localparam int CNT_W     = 21;
    localparam int CFG_DIM_W = 11;
    localparam int CFG_CNT_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int ROW_LIMIT = 256;
    localparam int CY_W      = 8;
    localparam int PIX_W     = 8;

    localparam logic [CFG_DIM_W-1:0] SRC_WIDTH_RST  = 11'd160;
    localparam logic [CFG_DIM_W-1:0] SRC_HEIGHT_RST = 11'd80;
    localparam logic [CFG_CNT_W-1:0] DST_COLS_RST   = 9'd76;
    localparam logic [CFG_CNT_W-1:0] DST_ROWS_RST   = 9'd19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_COLS   = 3'd2,
        CFG_DST_ROWS   = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SUM_W-1:0] red_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] blue_sum;
        logic [SUM_W-1:0] alpha_sum;
        logic [CNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/aad_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/area_average_downscaler.sv */
// Area-average downscaler: a pixel inside a cell passes the idle and update states; a cell
// edge crossing adds an edge divide; a completed cell adds four average divides, an edge
// divide (none on the last cell of an image) and the output state, plus any output stall.
// All of the divides share one restoring divider.
// Reset (aresetn low, synchronous) loads the default registers and clears the position;
// then, and after writes to registers 0-3, the first edges are divided before ready rises.
`include "assert_macros.svh"

module area_average_downscaler #(
    parameter int MAX_COLS    = 256,
    parameter int MAX_SRC_DIM = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [aad_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [aad_pkg::CFG_DIM_W-1:0] cfg_data,
    // source pixel requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_start_of_frame,
    input  logic [aad_pkg::PIX_W-1:0]     s_pix_red,
    input  logic [aad_pkg::PIX_W-1:0]     s_pix_green,
    input  logic [aad_pkg::PIX_W-1:0]     s_pix_blue,
    input  logic [aad_pkg::PIX_W-1:0]     s_pix_alpha,
    // completed cell requests
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_cell_col,
    output logic [7:0]                    m_cell_row,
    output logic [aad_pkg::PIX_W-1:0]     m_avg_red,
    output logic [aad_pkg::PIX_W-1:0]     m_avg_green,
    output logic [aad_pkg::PIX_W-1:0]     m_avg_blue,
    output logic [aad_pkg::PIX_W-1:0]     m_avg_alpha,
    output logic                          m_frame_done
);

    import aad_pkg::*;

    localparam int DIM_W = $clog2(MAX_SRC_DIM + 1);   // sizes and edges
    localparam int COL_W = $clog2(MAX_COLS + 1);      // column counts
    localparam int CX_W  = $clog2(MAX_COLS);          // column index / RAM address
    localparam int ROW_W = $clog2(ROW_LIMIT + 1);     // row counts
    localparam int MUL_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int NUM_W = MUL_W + DIM_W;             // edge numerator
    localparam int QW    = SUM_W;                     // divider quotient bits
    localparam int DW    = CNT_W;                     // divider divisor bits
    localparam int DC_W  = $clog2(QW);

    typedef enum logic [2:0] {
        S_LOAD, S_DIV, S_IDLE, S_MOD, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        J_RED, J_GRN, J_BLU, J_ALP, J_EDGE, J_INIT_COL, J_INIT_ROW
    } job_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t               state_reg;
    job_t                 job_reg;

    logic [CFG_DIM_W-1:0] src_width_reg, src_height_reg;
    logic [CFG_CNT_W-1:0] dst_cols_reg, dst_rows_reg;

    logic [DIM_W-1:0]     pixel_x_reg, pixel_y_reg;
    logic [CX_W-1:0]      cell_x_reg;
    logic [CY_W-1:0]      cell_y_reg;
    logic [DIM_W-1:0]     next_col_edge_reg, next_row_edge_reg;
    logic [DIM_W-1:0]     first_col_edge_reg, first_row_edge_reg;
    logic                 band_first_reg, cell_first_reg;

    logic                 emit_pend_reg, edge_pend_reg, edge_row_reg;
    logic [NUM_W-1:0]     edge_num_reg;

    logic [PIX_W-1:0]     pix_red_reg, pix_green_reg, pix_blue_reg, pix_alpha_reg;
    entry_t               acc_reg;
    logic [7:0]           hold_col_reg, hold_row_reg;
    logic                 hold_done_reg;
    logic [PIX_W-1:0]     avg_red_reg, avg_green_reg, avg_blue_reg, avg_alpha_reg;

    logic [DW-1:0]        div_rem_reg, div_den_reg;
    logic [QW-1:0]        div_quo_reg;
    logic [DC_W-1:0]      div_cnt_reg;

    logic                 m_valid_reg;
    logic [7:0]           m_cell_col_reg, m_cell_row_reg;
    logic [PIX_W-1:0]     m_avg_red_reg, m_avg_green_reg, m_avg_blue_reg, m_avg_alpha_reg;
    logic                 m_frame_done_reg;

    // ------------------------------------------------------------------
    // Effective geometry: clamp sizes and cell counts
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] eff_w, eff_h;
    logic [COL_W-1:0] eff_cols;
    logic [ROW_W-1:0] eff_rows;

    always_comb begin
        logic [31:0] w, h, c, r;
        w = 32'(src_width_reg);
        if (w == 32'd0) w = 32'd1;
        if (w > 32'(MAX_SRC_DIM)) w = 32'(MAX_SRC_DIM);
        h = 32'(src_height_reg);
        if (h == 32'd0) h = 32'd1;
        if (h > 32'(MAX_SRC_DIM)) h = 32'(MAX_SRC_DIM);
        c = 32'(dst_cols_reg);
        if (c > w) c = w;
        if (c > 32'(MAX_COLS)) c = 32'(MAX_COLS);
        if (c == 32'd0) c = 32'd1;
        r = 32'(dst_rows_reg);
        if (r > h) r = h;
        if (r > 32'(ROW_LIMIT)) r = 32'(ROW_LIMIT);
        if (r == 32'd0) r = 32'd1;
        eff_w    = DIM_W'(w);
        eff_h    = DIM_W'(h);
        eff_cols = COL_W'(c);
        eff_rows = ROW_W'(r);
    end

    // ------------------------------------------------------------------
    // Column sum memory: one entry per cell column of the current band
    // ------------------------------------------------------------------
    logic          s_fire;
    logic          ram_we;
    logic [CX_W-1:0] ram_raddr;
    entry_t        ram_rdata, ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata_raw;

    // A register write takes the cycle, so hold off the pixel request then.
    assign s_ready   = (state_reg == S_IDLE) && !cfg_we;
    assign s_fire    = s_valid && s_ready;
    // A start of frame restarts at column 0, so read that entry instead.
    assign ram_raddr = s_start_of_frame ? '0 : cell_x_reg;
    assign ram_we    = (state_reg == S_MOD);
    assign ram_rdata = entry_t'(ram_rdata_raw);

    // The read data used is sampled in the idle state, after the write of
    // the previous pixel has completed, so the same entry never has a read in flight
    // while its update is pending.
    aad_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_COLS)
    ) u_sums (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cell_x_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    // ------------------------------------------------------------------
    // Accumulate and position update for the pixel in flight
    // ------------------------------------------------------------------
    entry_t           base;
    logic [DIM_W:0]   px1, py1;
    logic             col_hit, row_hit, wrap, frame_end, last_cell;
    logic [COL_W-1:0] cx_new;
    logic [ROW_W-1:0] cy1;
    logic [NUM_W-1:0] edge_col_num, edge_row_num;

    always_comb begin
        // First row of a band and first pixel of a cell: entry is stale, start from zero.
        base = (band_first_reg && cell_first_reg) ? '0 : ram_rdata;
        ram_wdata.red_sum   = base.red_sum   + SUM_W'(pix_red_reg);
        ram_wdata.green_sum = base.green_sum + SUM_W'(pix_green_reg);
        ram_wdata.blue_sum  = base.blue_sum  + SUM_W'(pix_blue_reg);
        ram_wdata.alpha_sum = base.alpha_sum + SUM_W'(pix_alpha_reg);
        ram_wdata.count     = base.count + CNT_W'(1);

        px1       = {1'b0, pixel_x_reg} + (DIM_W+1)'(1);
        py1       = {1'b0, pixel_y_reg} + (DIM_W+1)'(1);
        col_hit   = px1 >= {1'b0, next_col_edge_reg};
        row_hit   = py1 >= {1'b0, next_row_edge_reg};
        cx_new    = COL_W'(cell_x_reg) + COL_W'(col_hit);
        wrap      = (px1 >= {1'b0, eff_w}) || (cx_new >= eff_cols);
        cy1       = ROW_W'(cell_y_reg) + ROW_W'(1);
        frame_end = (py1 >= {1'b0, eff_h}) || (cy1 >= eff_rows);
        last_cell = ((COL_W'(cell_x_reg) + COL_W'(1)) >= eff_cols) && (cy1 >= eff_rows);

        edge_col_num = NUM_W'(cx_new + COL_W'(1)) * NUM_W'(eff_w);
        edge_row_num = NUM_W'(cy1 + ROW_W'(1)) * NUM_W'(eff_h);
    end

    // ------------------------------------------------------------------
    // Shared restoring divider: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [QW-1:0] op_num, div_quo_next;
    logic [DW-1:0] op_den, cnt_fix, div_rem_next;
    logic [DW:0]   div_shift;
    logic          div_ge, div_last;

    always_comb begin
        cnt_fix = (acc_reg.count == '0) ? DW'(1) : acc_reg.count;
        case (job_reg)
            J_RED: begin
                op_num = acc_reg.red_sum;
                op_den = cnt_fix;
            end
            J_GRN: begin
                op_num = acc_reg.green_sum;
                op_den = cnt_fix;
            end
            J_BLU: begin
                op_num = acc_reg.blue_sum;
                op_den = cnt_fix;
            end
            J_ALP: begin
                op_num = acc_reg.alpha_sum;
                op_den = cnt_fix;
            end
            J_EDGE: begin
                op_num = QW'(edge_num_reg);
                op_den = edge_row_reg ? DW'(eff_rows) : DW'(eff_cols);
            end
            J_INIT_COL: begin
                op_num = QW'(eff_w);
                op_den = DW'(eff_cols);
            end
            J_INIT_ROW: begin
                op_num = QW'(eff_h);
                op_den = DW'(eff_rows);
            end
            default: begin
                op_num = '0;
                op_den = DW'(1);
            end
        endcase

        div_shift    = {div_rem_reg, div_quo_reg[QW-1]};
        div_ge       = div_shift >= {1'b0, div_den_reg};
        div_rem_next = div_ge ? DW'(div_shift - {1'b0, div_den_reg}) : div_shift[DW-1:0];
        div_quo_next = {div_quo_reg[QW-2:0], div_ge};
        div_last     = (div_cnt_reg == DC_W'(QW - 1));
    end

    // ------------------------------------------------------------------
    // Sequencer: state, position, divider and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_LOAD;
            job_reg            <= J_INIT_COL;
            src_width_reg      <= SRC_WIDTH_RST;
            src_height_reg     <= SRC_HEIGHT_RST;
            dst_cols_reg       <= DST_COLS_RST;
            dst_rows_reg       <= DST_ROWS_RST;
            pixel_x_reg        <= '0;
            pixel_y_reg        <= '0;
            cell_x_reg         <= '0;
            cell_y_reg         <= '0;
            next_col_edge_reg  <= '0;
            next_row_edge_reg  <= '0;
            first_col_edge_reg <= '0;
            first_row_edge_reg <= '0;
            band_first_reg     <= 1'b1;
            cell_first_reg     <= 1'b1;
            emit_pend_reg      <= 1'b0;
            edge_pend_reg      <= 1'b0;
            edge_row_reg       <= 1'b0;
            div_cnt_reg        <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            // Drop the output request once taken, unless a new cell replaces it now.
            if (m_valid_reg && m_ready && (cfg_we || state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                // A write to a defined register restarts the frame and recomputes the first edges.
                case (cfg_index_t'(cfg_index))
                    CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                    CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                    CFG_DST_COLS:   dst_cols_reg   <= cfg_data[CFG_CNT_W-1:0];
                    CFG_DST_ROWS:   dst_rows_reg   <= cfg_data[CFG_CNT_W-1:0];
                    default: ;
                endcase
                if (cfg_index_t'(cfg_index) == CFG_SRC_WIDTH  ||
                    cfg_index_t'(cfg_index) == CFG_SRC_HEIGHT ||
                    cfg_index_t'(cfg_index) == CFG_DST_COLS   ||
                    cfg_index_t'(cfg_index) == CFG_DST_ROWS) begin
                    pixel_x_reg    <= '0;
                    pixel_y_reg    <= '0;
                    cell_x_reg     <= '0;
                    cell_y_reg     <= '0;
                    band_first_reg <= 1'b1;
                    cell_first_reg <= 1'b1;
                    emit_pend_reg  <= 1'b0;
                    edge_pend_reg  <= 1'b0;
                    job_reg        <= J_INIT_COL;
                    state_reg      <= S_LOAD;
                end
            end else begin
                case (state_reg)
                    S_IDLE: begin
                        if (s_fire) begin
                            pix_red_reg   <= s_pix_red;
                            pix_green_reg <= s_pix_green;
                            pix_blue_reg  <= s_pix_blue;
                            pix_alpha_reg <= s_pix_alpha;
                            if (s_start_of_frame) begin
                                pixel_x_reg       <= '0;
                                pixel_y_reg       <= '0;
                                cell_x_reg        <= '0;
                                cell_y_reg        <= '0;
                                next_col_edge_reg <= first_col_edge_reg;
                                next_row_edge_reg <= first_row_edge_reg;
                                band_first_reg    <= 1'b1;
                                cell_first_reg    <= 1'b1;
                            end
                            state_reg <= S_MOD;
                        end
                    end

                    S_MOD: begin
                        acc_reg       <= ram_wdata;
                        hold_col_reg  <= 8'(cell_x_reg);
                        hold_row_reg  <= cell_y_reg;
                        hold_done_reg <= last_cell;
                        emit_pend_reg <= col_hit && row_hit;
                        // A new column edge inside the row, or a new row edge at a band end.
                        edge_pend_reg <= (col_hit && !wrap) || (wrap && row_hit && !frame_end);

                        if (wrap) begin
                            pixel_x_reg       <= '0;
                            cell_x_reg        <= '0;
                            next_col_edge_reg <= first_col_edge_reg;
                            cell_first_reg    <= 1'b1;
                            if (row_hit) begin
                                band_first_reg <= 1'b1;
                                if (frame_end) begin
                                    pixel_y_reg       <= '0;
                                    cell_y_reg        <= '0;
                                    next_row_edge_reg <= first_row_edge_reg;
                                end else begin
                                    pixel_y_reg   <= DIM_W'(py1);
                                    cell_y_reg    <= CY_W'(cy1);
                                    edge_row_reg  <= 1'b1;
                                    edge_num_reg  <= edge_row_num;
                                end
                            end else begin
                                band_first_reg <= 1'b0;
                                pixel_y_reg    <= DIM_W'(py1);
                            end
                        end else begin
                            pixel_x_reg    <= DIM_W'(px1);
                            cell_x_reg     <= CX_W'(cx_new);
                            cell_first_reg <= col_hit;
                            if (col_hit) begin
                                edge_row_reg  <= 1'b0;
                                edge_num_reg  <= edge_col_num;
                            end
                        end

                        // Averages first, then the edge; nothing to divide means done.
                        if (col_hit && row_hit) begin
                            job_reg   <= J_RED;
                            state_reg <= S_LOAD;
                        end else if (col_hit && !wrap) begin
                            job_reg   <= J_EDGE;
                            state_reg <= S_LOAD;
                        end else if (wrap && row_hit && !frame_end) begin
                            job_reg   <= J_EDGE;
                            state_reg <= S_LOAD;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end

                    S_LOAD: begin
                        div_rem_reg <= '0;
                        div_quo_reg <= op_num;
                        div_den_reg <= op_den;
                        div_cnt_reg <= '0;
                        state_reg   <= S_DIV;
                    end

                    S_DIV: begin
                        div_rem_reg <= div_rem_next;
                        div_quo_reg <= div_quo_next;
                        div_cnt_reg <= div_cnt_reg + DC_W'(1);
                        if (div_last) begin
                            case (job_reg)
                                J_RED: begin
                                    avg_red_reg <= div_quo_next[PIX_W-1:0];
                                    job_reg     <= J_GRN;
                                    state_reg   <= S_LOAD;
                                end
                                J_GRN: begin
                                    avg_green_reg <= div_quo_next[PIX_W-1:0];
                                    job_reg       <= J_BLU;
                                    state_reg     <= S_LOAD;
                                end
                                J_BLU: begin
                                    avg_blue_reg <= div_quo_next[PIX_W-1:0];
                                    job_reg      <= J_ALP;
                                    state_reg    <= S_LOAD;
                                end
                                J_ALP: begin
                                    avg_alpha_reg <= div_quo_next[PIX_W-1:0];
                                    if (edge_pend_reg) begin
                                        job_reg   <= J_EDGE;
                                        state_reg <= S_LOAD;
                                    end else begin
                                        state_reg <= S_OUT;
                                    end
                                end
                                J_EDGE: begin
                                    if (edge_row_reg) begin
                                        next_row_edge_reg <= DIM_W'(div_quo_next);
                                    end else begin
                                        next_col_edge_reg <= DIM_W'(div_quo_next);
                                    end
                                    edge_pend_reg <= 1'b0;
                                    state_reg     <= emit_pend_reg ? S_OUT : S_IDLE;
                                end
                                J_INIT_COL: begin
                                    first_col_edge_reg <= DIM_W'(div_quo_next);
                                    job_reg            <= J_INIT_ROW;
                                    state_reg          <= S_LOAD;
                                end
                                J_INIT_ROW: begin
                                    first_row_edge_reg <= DIM_W'(div_quo_next);
                                    next_row_edge_reg  <= DIM_W'(div_quo_next);
                                    next_col_edge_reg  <= first_col_edge_reg;
                                    state_reg          <= S_IDLE;
                                end
                                default: state_reg <= S_IDLE;
                            endcase
                        end
                    end

                    S_OUT: begin
                        // Hold until the output register is free, then hand the cell over.
                        if (!m_valid_reg || m_ready) begin
                            m_valid_reg      <= 1'b1;
                            m_cell_col_reg   <= hold_col_reg;
                            m_cell_row_reg   <= hold_row_reg;
                            m_avg_red_reg    <= avg_red_reg;
                            m_avg_green_reg  <= avg_green_reg;
                            m_avg_blue_reg   <= avg_blue_reg;
                            m_avg_alpha_reg  <= avg_alpha_reg;
                            m_frame_done_reg <= hold_done_reg;
                            emit_pend_reg    <= 1'b0;
                            state_reg        <= S_IDLE;
                        end
                    end

                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cell_col   = m_cell_col_reg;
    assign m_cell_row   = m_cell_row_reg;
    assign m_avg_red    = m_avg_red_reg;
    assign m_avg_green  = m_avg_green_reg;
    assign m_avg_blue   = m_avg_blue_reg;
    assign m_avg_alpha  = m_avg_alpha_reg;
    assign m_frame_done = m_frame_done_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `AAD_ASSERT_IMPLY(a_ram_index, aclk, aresetn, ram_we,
        32'(cell_x_reg) < 32'(eff_cols), "sum update beyond last cell column")
    `AAD_ASSERT_IMPLY(a_pos_in_row, aclk, aresetn, state_reg == S_IDLE,
        pixel_x_reg < eff_w, "pixel column past source width")
    `AAD_ASSERT_IMPLY(a_div_rem, aclk, aresetn, state_reg == S_DIV,
        div_rem_reg < div_den_reg, "divider remainder not below divisor")
    `AAD_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        state_reg == S_OUT && m_valid_reg && !m_ready && !cfg_we,
        state_reg == S_OUT && m_valid_reg, "pending cell overwrote unread output")

endmodule
